[rtl/tkfv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfv_pkg
// Shared types and constants for the top-k frequent values block.
// ----------------------------------------------------------------------------
package tkfv_pkg;

	localparam int VALUE_W          = 32;
	localparam int TOP_COUNT_W      = 7;
	localparam int RESULT_LIMIT     = 64;
	localparam int MAX_DISTINCT_DEF = 64;
	localparam int COUNT_WIDTH_DEF  = 16;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		logic                      last_result;
		logic                      table_overflow;
	} out_word_t;

endpackage

[rtl/top_k_frequent_values.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values
// Counts distinct values of a set and reports the most frequent ones.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one value of a set per word; is_last marks the final one.
//   Each word is matched against the table of distinct values by one shared
//   comparator that walks the table one entry at a time (registered memory
//   read, then compare and update). The block takes no new word until it is
//   through with the current one. After the last word the block reports
//   min(top_count, U) values on out_data, where U is the number of distinct
//   values in the table, a top_count of 0 counts as 1 and one above 64 as 64;
//   highest count first, ties by first appearance. Each reported value costs
//   one full table walk plus any output stall. last_result marks the final
//   report of the set; table_overflow is set on every report of a set in
//   which a new value found the table full. in_ready is high only while the
//   block waits for a word. The output register holds a word until out_ready
//   takes it; the next walk runs meanwhile and waits only to load its own
//   result. top_count is written through cfg_we/cfg_wdata; the user must
//   write it only while the block is idle, which the block does not enforce.
//   Reset empties the table, clears the overflow mark, sets top_count to 1.
// ----------------------------------------------------------------------------
module top_k_frequent_values
	import tkfv_pkg::*;
#(
	parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data,
	input  logic                   cfg_we,
	input  logic [TOP_COUNT_W-1:0] cfg_wdata
);

	localparam int IW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
	localparam int CW = $clog2(MAX_DISTINCT + 1);
	localparam int NW = (CW > TOP_COUNT_W) ? CW : TOP_COUNT_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MWAIT  = 3'd1;
	localparam logic [2:0] S_MCMP   = 3'd2;
	localparam logic [2:0] S_INSERT = 3'd3;
	localparam logic [2:0] S_SWAIT  = 3'd4;
	localparam logic [2:0] S_SCMP   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]               state_q;
	logic [TOP_COUNT_W-1:0]   top_count_q;
	logic [CW-1:0]            used_q;
	logic                     ovf_q;
	logic [IW-1:0]            idx_q;
	logic [VALUE_W-1:0]       val_q;
	logic                     last_q;

	logic [VALUE_W-1:0]       key_mem [MAX_DISTINCT];
	logic [COUNT_WIDTH-1:0]   cnt_mem [MAX_DISTINCT];
	logic [VALUE_W-1:0]       rd_key_q;
	logic [COUNT_WIDTH-1:0]   rd_cnt_q;

	logic                     mem_we;
	logic                     key_we;
	logic [IW-1:0]            wr_addr;
	logic [COUNT_WIDTH-1:0]   wr_cnt;

	// report walk
	logic [TOP_COUNT_W-1:0]   n_q;
	logic [TOP_COUNT_W-1:0]   r_q;
	logic                     first_q;
	logic [COUNT_WIDTH-1:0]   pc_q;
	logic [IW-1:0]            pi_q;
	logic                     found_q;
	logic [COUNT_WIDTH-1:0]   bc_q;
	logic [IW-1:0]            bi_q;
	logic [VALUE_W-1:0]       bkey_q;

	logic                     out_valid_q;
	out_word_t                out_q;

	logic                     walk_end;
	logic                     hit;
	logic                     eligible;
	logic                     take;
	logic                     out_free;
	logic                     final_pick;
	logic [TOP_COUNT_W-1:0]   want;
	logic [TOP_COUNT_W-1:0]   n_next;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign walk_end   = ((CW'(idx_q) + CW'(1)) == used_q);
	assign hit        = (rd_key_q == val_q);
	assign eligible   = first_q || (rd_cnt_q < pc_q) ||
	                    ((rd_cnt_q == pc_q) && (idx_q > pi_q));
	assign take       = eligible && (!found_q || (rd_cnt_q > bc_q));
	assign out_free   = !out_valid_q || out_ready;
	assign final_pick = ((r_q + TOP_COUNT_W'(1)) == n_q);

	always_comb begin
		if (top_count_q == '0) begin
			want = TOP_COUNT_W'(1);
		end else if (top_count_q > TOP_COUNT_W'(RESULT_LIMIT)) begin
			want = TOP_COUNT_W'(RESULT_LIMIT);
		end else begin
			want = top_count_q;
		end
		if (NW'(used_q) < NW'(want)) begin
			n_next = TOP_COUNT_W'(used_q);
		end else begin
			n_next = want;
		end
	end

	// table write: count update on a hit, new entry on insert while the table has room
	always_comb begin
		mem_we  = 1'b0;
		key_we  = 1'b0;
		wr_addr = idx_q;
		wr_cnt  = rd_cnt_q;
		if (state_q == S_MCMP && hit) begin
			mem_we = 1'b1;
			if (rd_cnt_q != '1) begin
				wr_cnt = rd_cnt_q + COUNT_WIDTH'(1);
			end
		end else if (state_q == S_INSERT && used_q < CW'(MAX_DISTINCT)) begin
			mem_we  = 1'b1;
			key_we  = 1'b1;
			wr_addr = IW'(used_q);
			wr_cnt  = COUNT_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (key_we) begin
			key_mem[wr_addr] <= val_q;
		end
		rd_key_q <= key_mem[idx_q];
		rd_cnt_q <= cnt_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_COUNT_W'(1);
		end else if (cfg_we) begin
			top_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			r_q         <= '0;
			first_q     <= 1'b1;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= (used_q == '0) ? S_INSERT : S_MWAIT;
					end
				end
				S_MWAIT: begin
					state_q <= S_MCMP;
				end
				S_MCMP: begin
					if (hit || walk_end) begin
						if (!hit) begin
							state_q <= S_INSERT;
						end else if (last_q) begin
							idx_q   <= '0;
							r_q     <= '0;
							n_q     <= n_next;
							first_q <= 1'b1;
							found_q <= 1'b0;
							state_q <= S_SWAIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_MWAIT;
					end
				end
				S_INSERT: begin
					if (used_q < CW'(MAX_DISTINCT)) begin
						used_q <= used_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (last_q) begin
						idx_q   <= '0;
						r_q     <= '0;
						// the new entry counts toward the report
						if (used_q < CW'(MAX_DISTINCT) &&
						    NW'(used_q) < NW'(want)) begin
							n_q <= TOP_COUNT_W'(used_q) + TOP_COUNT_W'(1);
						end else begin
							n_q <= n_next;
						end
						first_q <= 1'b1;
						found_q <= 1'b0;
						state_q <= S_SWAIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SWAIT: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (walk_end) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_SWAIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						first_q     <= 1'b0;
						r_q         <= r_q + TOP_COUNT_W'(1);
						if (final_pick) begin
							used_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SWAIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			val_q  <= in_data.value;
			last_q <= in_data.is_last;
		end
		if (state_q == S_SCMP && take) begin
			bc_q   <= rd_cnt_q;
			bi_q   <= idx_q;
			bkey_q <= rd_key_q;
		end
		if (state_q == S_EMIT && out_free) begin
			out_q.result_value   <= bkey_q;
			out_q.last_result    <= final_pick;
			out_q.table_overflow <= ovf_q;
			// next pick must rank strictly below this one
			pc_q <= bc_q;
			pi_q <= bi_q;
		end
	end

endmodule
